FILE: rtl/sdsc_pkg.sv
package sdsc_pkg;

   // Default width of one stick code
   localparam int CODE_BITS_DEF = 12;

   // Configuration register widths
   localparam int DZ_BITS   = 12;
   localparam int GAIN_BITS = 16;
   localparam int STEP_BITS = 13;

   // Fraction bits of the rescale gain
   localparam int GAIN_FRAC = 12;

   // Configuration port geometry
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   // Reset values of the configuration registers
   localparam logic [DZ_BITS-1:0]   DZ_RESET   = DZ_BITS'(410);
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(4551);
   localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(410);

   // Configuration register indexes
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_DEADZONE = 2'd0,
      CSR_GAIN     = 2'd1,
      CSR_STEP     = 2'd2
   } csr_index_type;

endpackage

FILE: rtl/stick_deadzone_slew_conditioner_top.sv
// Stick conditioner. Each transaction on req_ carries four stick codes
// (roll, pitch, yaw, thrust), CODE_BITS each. Every code is centered as
// 2*code - full (full = 2^CODE_BITS - 1); a magnitude below deadzone_width
// becomes zero, otherwise deadzone_width is taken off and the rest is
// multiplied by the Q12 rescale_gain, truncated and saturated at full scale.
// Thrust is then slew-limited: it moves at most max_thrust_step centered
// units away from the previous thrust, which starts at centre after reset.
// All four channels are re-encoded as (c + full) >> 1 and leave as one
// transaction on rsp_. One result follows each input. Timing: the block
// takes one transaction per clock while rsp_ is not stalled; an accepted
// transaction loads the input register, then the product register after
// the multipliers, then the result register holding the saturate/slew/
// encode output, which drives rsp_tvalid.
// Up to three transactions are in flight; a stalled rsp_ side holds every
// full stage, while earlier data still moves into empty stages. The csr_
// port is always ready; write it only while no transaction is in flight.
// Indexes beyond the register list are ignored.
module stick_deadzone_slew_conditioner_top #(
   parameter int CODE_BITS = sdsc_pkg::CODE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: roll_code, pitch_code, yaw_code, thrust_code (from bit 0 up)
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((4*CODE_BITS+7)/8)*8-1:0]      req_tdata,
   // rsp_tdata: roll_out, pitch_out, yaw_out, thrust_out (from bit 0 up)
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((4*CODE_BITS+7)/8)*8-1:0]      rsp_tdata,
   // Configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sdsc_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [sdsc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import sdsc_pkg::*;

   localparam int AXES       = 4;
   localparam int THRUST     = 3;
   localparam int PROD_BITS  = CODE_BITS + GAIN_BITS;
   localparam int SCALE_BITS = PROD_BITS - GAIN_FRAC;
   localparam int SLEW_BITS  = ((CODE_BITS > STEP_BITS) ? CODE_BITS : STEP_BITS) + 3;
   localparam logic [CODE_BITS-1:0] FULL = '1;

   // Configuration registers
   logic [DZ_BITS-1:0]   deadzone_ff, deadzone_in;
   logic [GAIN_BITS-1:0] gain_ff,     gain_in;
   logic [STEP_BITS-1:0] step_ff,     step_in;

   // Input stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [CODE_BITS-1:0] code_ff [AXES];
   logic [CODE_BITS-1:0] code_in [AXES];

   // Product stage
   logic                 s2_valid_ff, s2_valid_in;
   logic [PROD_BITS-1:0] prod_ff [AXES];
   logic [PROD_BITS-1:0] prod_in [AXES];
   logic                 neg_ff  [AXES];
   logic                 neg_in  [AXES];

   // Result stage and thrust history
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CODE_BITS-1:0]        result_ff [AXES];
   logic [CODE_BITS-1:0]        result_in [AXES];
   logic signed [CODE_BITS+1:0] prev_thrust_ff, prev_thrust_in;

   logic s1_ready, s2_ready, out_ready;
   logic s1_load, s2_advance;

   logic signed [CODE_BITS:0]   centered [AXES];
   logic signed [SLEW_BITS-1:0] thr_w, prev_w, step_w, diff_w, slewed_w;

   // Saturate a shifted product at full scale and restore the sign
   function automatic logic signed [CODE_BITS:0] restore_sign(
      input logic [PROD_BITS-1:0] prod,
      input logic                 neg
   );
      logic [SCALE_BITS-1:0]     scaled;
      logic [CODE_BITS-1:0]      sat;
      logic signed [CODE_BITS:0] mag;
      scaled = prod[PROD_BITS-1:GAIN_FRAC];
      sat    = (scaled > SCALE_BITS'(FULL)) ? FULL : scaled[CODE_BITS-1:0];
      mag    = $signed({1'b0, sat});
      return neg ? -mag : mag;
   endfunction

   // Re-encode a centered value as (c + full) >> 1
   function automatic logic [CODE_BITS-1:0] encode(input logic signed [CODE_BITS:0] c);
      logic signed [CODE_BITS+1:0] sum;
      sum = (CODE_BITS+2)'(c) + $signed({2'b00, FULL});
      return sum[CODE_BITS:1];
   endfunction

   // Pipeline flow: a stage loads when it is empty or its content moves on
   assign out_ready  = ~rsp_valid_ff | rsp_tready;
   assign s2_ready   = ~s2_valid_ff | out_ready;
   assign s1_ready   = ~s1_valid_ff | s2_ready;
   assign req_tready = s1_ready;
   assign s1_load    = req_tvalid & s1_ready;
   assign s2_advance = s2_valid_ff & out_ready;
   assign csr_ready  = 1'b1;

   // Configuration writes
   always_comb begin
      deadzone_in = deadzone_ff;
      gain_in     = gain_ff;
      step_in     = step_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            CSR_DEADZONE: deadzone_in = csr_wdata[DZ_BITS-1:0];
            CSR_GAIN:     gain_in     = csr_wdata[GAIN_BITS-1:0];
            CSR_STEP:     step_in     = csr_wdata[STEP_BITS-1:0];
            default: begin
               // Drop writes beyond the register list
            end
         endcase
      end
   end

   // Input stage: capture the four codes
   always_comb begin
      s1_valid_in = s1_ready ? req_tvalid : s1_valid_ff;
      for (int i = 0; i < AXES; i++) begin
         code_in[i] = s1_load ? req_tdata[i*CODE_BITS +: CODE_BITS] : code_ff[i];
      end
   end

   // Deadzone and gain per axis, one multiplier each
   for (genvar g = 0; g < AXES; g++) begin : g_axis
      sdsc_axis_shaper #(
         .CODE_BITS (CODE_BITS)
      ) u_shaper (
         .code     (code_ff[g]),
         .deadzone (deadzone_ff),
         .gain     (gain_ff),
         .product  (prod_in[g]),
         .negative (neg_in[g])
      );
   end

   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   // Result stage: saturate, slew-limit thrust, encode
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         centered[i] = restore_sign(prod_ff[i], neg_ff[i]);
      end

      thr_w  = SLEW_BITS'(centered[THRUST]);
      prev_w = SLEW_BITS'(prev_thrust_ff);
      step_w = $signed(SLEW_BITS'(step_ff));
      diff_w = thr_w - prev_w;
      priority if (diff_w > step_w) begin
         slewed_w = prev_w + step_w;
      end else if (diff_w < -step_w) begin
         slewed_w = prev_w - step_w;
      end else begin
         slewed_w = thr_w;
      end

      for (int i = 0; i < AXES; i++) begin
         result_in[i] = result_ff[i];
      end
      prev_thrust_in = prev_thrust_ff;
      if (s2_advance) begin
         for (int i = 0; i < THRUST; i++) begin
            result_in[i] = encode(centered[i]);
         end
         result_in[THRUST] = encode(slewed_w[CODE_BITS:0]);
         prev_thrust_in    = slewed_w[CODE_BITS+1:0];
      end

      rsp_valid_in = out_ready ? s2_valid_ff : rsp_valid_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff    <= DZ_RESET;
         gain_ff        <= GAIN_RESET;
         step_ff        <= STEP_RESET;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         prev_thrust_ff <= '0;
      end else begin
         deadzone_ff    <= deadzone_in;
         gain_ff        <= gain_in;
         step_ff        <= step_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         prev_thrust_ff <= prev_thrust_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < AXES; i++) begin
         code_ff[i]   <= code_in[i];
         result_ff[i] <= result_in[i];
         if (s2_ready) begin
            prod_ff[i] <= prod_in[i];
            neg_ff[i]  <= neg_in[i];
         end
      end
   end

   // Output packing
   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < AXES; i++) begin
         rsp_tdata[i*CODE_BITS +: CODE_BITS] = result_ff[i];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/sdsc_axis_shaper.sv
// Center one stick code, remove the deadzone and multiply by the gain.
// The product is left unshifted and unsaturated; the caller registers it.
module sdsc_axis_shaper #(
   parameter int CODE_BITS = sdsc_pkg::CODE_BITS_DEF
) (
   input  logic [CODE_BITS-1:0]                     code,
   input  logic [sdsc_pkg::DZ_BITS-1:0]             deadzone,
   input  logic [sdsc_pkg::GAIN_BITS-1:0]           gain,
   output logic [CODE_BITS+sdsc_pkg::GAIN_BITS-1:0] product,
   output logic                                     negative
);
   import sdsc_pkg::*;

   localparam int CMP_BITS  = (CODE_BITS > DZ_BITS) ? CODE_BITS : DZ_BITS;
   localparam int PROD_BITS = CODE_BITS + GAIN_BITS;
   localparam logic [CODE_BITS:0] FULL_X = {1'b0, {CODE_BITS{1'b1}}};

   logic [CODE_BITS:0]   twice;
   logic [CODE_BITS:0]   mag_x;
   logic [CMP_BITS-1:0]  mag_c;
   logic [CMP_BITS-1:0]  dz_c;
   logic [CMP_BITS-1:0]  excess_c;
   logic [CODE_BITS-1:0] excess;
   logic                 in_deadzone;

   // Centered value 2*code - full is negative for the lower half of the codes
   assign twice    = {code, 1'b0};
   assign negative = ~code[CODE_BITS-1];
   assign mag_x    = negative ? (FULL_X - twice) : (twice - FULL_X);

   assign mag_c       = CMP_BITS'(mag_x[CODE_BITS-1:0]);
   assign dz_c        = CMP_BITS'(deadzone);
   assign in_deadzone = mag_c < dz_c;
   assign excess_c    = mag_c - dz_c;
   assign excess      = in_deadzone ? '0 : excess_c[CODE_BITS-1:0];

   assign product = PROD_BITS'(excess) * PROD_BITS'(gain);

endmodule

FILE: rtl/sdsc_checker.sv
module sdsc_checker #(
   parameter int CODE_BITS = sdsc_pkg::CODE_BITS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [((4*CODE_BITS+7)/8)*8-1:0] rsp_tdata
);
   import sdsc_pkg::*;

   localparam int DEPTH = 3;

   logic [2:0] inflight_ff, inflight_in;
   logic       in_acc, out_acc;

   assign in_acc  = req_tvalid & req_tready;
   assign out_acc = rsp_tvalid & rsp_tready;

   always_comb begin
      inflight_in = inflight_ff;
      if (in_acc & ~out_acc) begin
         inflight_in = inflight_ff + 3'd1;
      end else if (out_acc & ~in_acc) begin
         inflight_in = inflight_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // No result is shown right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A result is shown only for a transaction that went in
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (inflight_ff != 3'd0))
      else $error("result without a pending transaction");

   // The pipeline never holds more than its three stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 3'(DEPTH))
      else $error("more transactions in flight than stages");

   // A stalled result holds its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind stick_deadzone_slew_conditioner_top sdsc_checker #(
   .CODE_BITS (CODE_BITS)
) u_sdsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
